// ===== design/hrcc_pkg.sv =====
// shared constants and helpers for the request completeness checker
package hrcc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_NEED_MORE = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [3:0]  KEY_LEN = 4'd14;
  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

  // "content-length", one character per match position
  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= CH_UP_A && b <= CH_UP_Z) ? (b + 8'd32) : b;
  endfunction

endpackage

// ===== design/http_request_completeness_checker.sv =====
// request completeness checker: byte-wise request line and header framing
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, in_data_byte, in_last_byte | into block
//  out     | out_valid, out_stall, out_status,              | out of block
//          | out_header_length, out_body_length             |
//
// one byte per cycle when in_stall is low; a last byte is held in the input
// register first, and the result register loads as that byte moves on
// the per-byte parse state update is the one loop, through the parse state registers
// reset clears the parse state, so a new request starts after rst_n
// in_stall rises only when a last byte waits in the input register while an
// earlier result is still held; other bytes keep flowing under out_stall
module http_request_completeness_checker #(
  parameter int COUNT_WIDTH = hrcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_header_length,
  output logic [30:0] out_body_length
);
  import hrcc_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > 31) ? COUNT_WIDTH : 31;
  localparam int HDR_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  typedef enum logic [2:0] {
    PH_FIRST, PH_REQ, PH_LINE, PH_KEY, PH_SKIP, PH_VALUE, PH_DONE, PH_BAD
  } phase_t;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // parse state
  phase_t                 phase_r, phase_nxt;
  logic                   prev_ws_r, prev_ws_nxt;
  logic [1:0]             runs_r, runs_nxt;
  logic [3:0]             key_pos_r, key_pos_nxt;
  logic                   key_match_r, key_match_nxt;
  logic                   key_cr_r, key_cr_nxt;
  logic                   val_digits_r, val_digits_nxt;
  logic                   val_cr_r, val_cr_nxt;
  logic [30:0]            val_acc_r, val_acc_nxt;
  logic [30:0]            len_r, len_nxt;
  logic                   len_ok_r, len_ok_nxt;
  logic [COUNT_WIDTH-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [COUNT_WIDTH-1:0] body_cnt_r, body_cnt_nxt;

  // result register
  logic        out_valid_r;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_hdr_r, out_hdr_nxt;
  logic [30:0] out_body_r, out_body_nxt;

  logic s1_move;
  logic s1_load;

  // a byte with no result may always move on; a last byte needs a free slot
  assign s1_move  = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign s1_load  = in_valid && !in_stall;

  // key step inputs: a fresh line starts from a cleared key
  logic [3:0]  kin_pos;
  logic        kin_match;
  logic        kin_cr;
  logic [3:0]  kb_pos;
  logic        kb_match;
  logic        kb_cr;
  logic        kb_colon;
  logic [7:0]  b;
  logic        b_ws;
  logic [3:0]  dig;
  logic [34:0] acc_ext;
  logic [34:0] acc_prod;
  logic        acc_ovf;
  logic        vb_digits;
  logic [30:0] vb_acc;

  assign b    = s1_byte_r;
  assign b_ws = is_ws(b);

  always_comb begin
    kin_pos   = (phase_r == PH_LINE) ? 4'd0 : key_pos_r;
    kin_match = (phase_r == PH_LINE) ? 1'b1 : key_match_r;
    kin_cr    = (phase_r == PH_LINE) ? 1'b0 : key_cr_r;
    kb_colon  = (b == CH_COLON);
    kb_pos    = kin_pos;
    kb_match  = kin_match;
    kb_cr     = kin_cr;
    if (kb_colon) begin
      kb_match = kin_match && (kin_pos == KEY_LEN);
    end else begin
      kb_match = kin_match && !kin_cr;
      kb_cr    = (b == CH_CR);
      if (b != CH_CR) begin
        if (kin_pos < KEY_LEN && to_lower(b) == key_char(kin_pos)) begin
          kb_pos = kin_pos + 4'd1;
        end else begin
          kb_match = 1'b0;
        end
      end
    end
  end

  // value digit accumulation, times ten as shift and add
  always_comb begin
    dig       = b[3:0] - CH_ZERO[3:0];
    acc_ext   = {4'b0, val_acc_r};
    acc_prod  = (acc_ext << 3) + (acc_ext << 1) + {31'b0, dig};
    acc_ovf   = acc_prod > {4'b0, LEN_MAX};
    vb_digits = val_digits_r && !val_cr_r;
    vb_acc    = val_acc_r;
    if (b != CH_CR) begin
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (acc_ovf) begin
          vb_digits = 1'b0;
        end else begin
          vb_acc = acc_prod[30:0];
        end
      end else begin
        vb_digits = 1'b0;
      end
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    prev_ws_nxt    = prev_ws_r;
    runs_nxt       = runs_r;
    key_pos_nxt    = key_pos_r;
    key_match_nxt  = key_match_r;
    key_cr_nxt     = key_cr_r;
    val_digits_nxt = val_digits_r;
    val_cr_nxt     = val_cr_r;
    val_acc_nxt    = val_acc_r;
    len_nxt        = len_r;
    len_ok_nxt     = len_ok_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    body_cnt_nxt   = body_cnt_r;

    if (phase_r == PH_DONE) begin
      if (body_cnt_r != '1) body_cnt_nxt = body_cnt_r + COUNT_WIDTH'(1);
    end else if (phase_r != PH_BAD) begin
      if (hdr_cnt_r != '1) hdr_cnt_nxt = hdr_cnt_r + COUNT_WIDTH'(1);
    end

    case (phase_r)
      PH_FIRST: begin
        prev_ws_nxt = b_ws;
        phase_nxt   = PH_REQ;
      end
      PH_REQ: begin
        if (b == CH_LF) begin
          phase_nxt     = (runs_r == 2'd2) ? PH_LINE : PH_BAD;
          key_pos_nxt   = 4'd0;
          key_match_nxt = 1'b1;
          key_cr_nxt    = 1'b0;
        end else begin
          if (b != CH_CR && b_ws && !prev_ws_r && runs_r != 2'd3) begin
            runs_nxt = runs_r + 2'd1;
          end
          prev_ws_nxt = b_ws;
        end
      end
      PH_LINE, PH_KEY: begin
        if (b == CH_LF) begin
          if (phase_r == PH_LINE) begin
            phase_nxt = len_ok_r ? PH_DONE : PH_BAD;
          end else begin
            phase_nxt = PH_BAD;
          end
        end else if (!(phase_r == PH_LINE && b == CH_CR)) begin
          key_pos_nxt   = kb_pos;
          key_match_nxt = kb_match;
          key_cr_nxt    = kb_cr;
          if (kb_colon) begin
            val_digits_nxt = 1'b1;
            val_cr_nxt     = 1'b0;
            val_acc_nxt    = '0;
            phase_nxt      = PH_SKIP;
          end else begin
            phase_nxt = PH_KEY;
          end
        end
      end
      PH_SKIP, PH_VALUE: begin
        if (b == CH_LF) begin
          if (phase_r == PH_SKIP) begin
            phase_nxt = PH_BAD;  // empty value
          end else begin
            if (key_match_r) begin
              len_ok_nxt = val_digits_r;
              len_nxt    = val_digits_r ? val_acc_r : '0;
            end
            key_pos_nxt   = 4'd0;
            key_match_nxt = 1'b1;
            key_cr_nxt    = 1'b0;
            phase_nxt     = PH_LINE;
          end
        end else if (phase_r == PH_VALUE || !b_ws) begin
          val_digits_nxt = vb_digits;
          val_cr_nxt     = (b == CH_CR);
          val_acc_nxt    = vb_acc;
          phase_nxt      = PH_VALUE;
        end
      end
      default: begin
      end
    endcase
  end

  // result from the state after this byte
  logic [CMP_W-1:0] body_cmp;
  logic [CMP_W-1:0] len_cmp;
  logic [HDR_W-1:0] hdr_ext;

  always_comb begin
    body_cmp = CMP_W'(body_cnt_nxt);
    len_cmp  = CMP_W'(len_nxt);
    hdr_ext  = HDR_W'(hdr_cnt_nxt);
    if (phase_nxt == PH_DONE) begin
      out_status_nxt = (body_cmp >= len_cmp) ? ST_COMPLETE : ST_NEED_MORE;
      out_hdr_nxt    = (hdr_ext > HDR_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : hdr_ext[31:0];
      out_body_nxt   = len_nxt;
    end else begin
      out_status_nxt = (phase_nxt == PH_BAD) ? ST_MALFORMED : ST_NEED_MORE;
      out_hdr_nxt    = '0;
      out_body_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      phase_r      <= PH_FIRST;
      prev_ws_r    <= 1'b0;
      runs_r       <= 2'd0;
      key_pos_r    <= 4'd0;
      key_match_r  <= 1'b1;
      key_cr_r     <= 1'b0;
      val_digits_r <= 1'b1;
      val_cr_r     <= 1'b0;
      val_acc_r    <= '0;
      len_r        <= '0;
      len_ok_r     <= 1'b1;
      hdr_cnt_r    <= '0;
      body_cnt_r   <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_move) begin
        phase_r      <= phase_nxt;
        prev_ws_r    <= prev_ws_nxt;
        runs_r       <= runs_nxt;
        key_pos_r    <= key_pos_nxt;
        key_match_r  <= key_match_nxt;
        key_cr_r     <= key_cr_nxt;
        val_digits_r <= val_digits_nxt;
        val_cr_r     <= val_cr_nxt;
        val_acc_r    <= val_acc_nxt;
        len_r        <= len_nxt;
        len_ok_r     <= len_ok_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        body_cnt_r   <= body_cnt_nxt;
      end
    end
    if (s1_load) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (s1_move && s1_last_r) begin
      out_status_r <= out_status_nxt;
      out_hdr_r    <= out_hdr_nxt;
      out_body_r   <= out_body_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_header_length = out_hdr_r;
  assign out_body_length   = out_body_r;

`ifndef SYNTHESIS
  a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BAD |=> phase_r == PH_BAD)
    else $error("malformed state left without reset");

  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_MALFORMED |-> out_header_length == 32'd0
      && out_body_length == 31'd0)
    else $error("malformed result carries lengths");

  a_complete_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_MALFORMED && (out_status != ST_COMPLETE
      || out_header_length != 32'd0))
    else $error("bad status or empty header on complete result");

  a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && s1_valid_r && s1_last_r |-> in_stall)
    else $error("last byte taken while result slot held");
`endif

endmodule
